### design/sme_pkg.sv
// ----------------------------------------------------------------------------
// Stable matching engine package
// Field widths, request codes and sequencer state encoding shared by the
// stable matching engine.
// ----------------------------------------------------------------------------
package sme_pkg;

	// Configuration register: number of people taking part
	localparam int CFG_W = 5;
	localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

	// Field widths of one request and one result
	localparam int REQ_W      = 2;
	localparam int FIELD_W    = 4;
	localparam int IN_DATA_W  = 16;
	localparam int OUT_DATA_W = 8;

	// Request kinds carried on the slave-side tuser
	typedef enum logic [REQ_W-1:0] {
		REQ_LOAD_PROPOSER = 2'd0,
		REQ_LOAD_ACCEPTOR = 2'd1,
		REQ_RUN           = 2'd2,
		REQ_NONE          = 2'd3
	} req_type_t;

	// Sequencer states, one-hot
	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_HEAD = 7'b0000010,
		ST_PREF = 7'b0000100,
		ST_PROP = 7'b0001000,
		ST_RANK = 7'b0010000,
		ST_CMP  = 7'b0100000,
		ST_OUT  = 7'b1000000
	} sme_state_t;

endpackage

### design/stable_matching_engine.sv
// Operation: a load transfer gives no result. A run transfer clears the run state as
// it is taken, then works through proposal steps (at most N*N, plus the dropping of
// each proposer whose list runs out), finds the queue empty, and then sends N result
// transfers, which the result stream may stall. Throughput: one item at a time; the
// sequencer and its single preference and rank memory ports set the run time. Reset
// clears the control state and the count to 16.
// ----------------------------------------------------------------------------
// Stable matching engine
// Proposer-optimal deferred acceptance over up to MAX_PEOPLE proposers and
// acceptors, driven by a small sequencer around one compare unit.
// ----------------------------------------------------------------------------
module stable_matching_engine #(
	parameter int MAX_PEOPLE = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// Configuration: number of people, written while the block is idle
	input  logic                           cfg_wr_en,
	input  logic [sme_pkg::CFG_W-1:0]      cfg_wr_data,
	// Request stream
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// [3:0] person, [7:4] position, [11:8] preferred, [15:12] zero
	input  logic [sme_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	// [1:0] req_type
	input  logic [sme_pkg::REQ_W-1:0]      s_axis_tuser,
	// Result stream
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// [3:0] acceptor, [7:4] partner
	output logic [sme_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	// [0] matched
	output logic                           m_axis_tuser,
	output logic                           m_axis_tlast
);
	import sme_pkg::*;

	// Index of one person, count of people, and table address widths
	localparam int IDX_W     = (MAX_PEOPLE > 1) ? $clog2(MAX_PEOPLE) : 1;
	localparam int CNT_W     = $clog2(MAX_PEOPLE + 1);
	localparam int SUM_W     = IDX_W + 1;
	localparam int ADDR_W    = 2 * IDX_W;
	localparam int MEM_DEPTH = 1 << ADDR_W;

	sme_state_t state_q;

	logic [CFG_W-1:0]   num_people_q;
	logic [CNT_W-1:0]   n_q;

	// Per-person run state held in flip-flops; next choice and engaged flags
	// are cleared together when a run starts.
	logic [CNT_W-1:0]   next_choice_q [MAX_PEOPLE];
	logic [MAX_PEOPLE-1:0] engaged_flag_q;
	logic [IDX_W-1:0]   engaged_to_q  [MAX_PEOPLE];

	// Queue of free proposers
	logic [IDX_W-1:0]   free_fifo_q   [MAX_PEOPLE];
	logic [IDX_W-1:0]   fifo_head_q;
	logic [CNT_W-1:0]   fifo_count_q;

	// Working registers of the current proposal step. acc_q also serves as
	// the acceptor index while the results are being sent.
	logic [IDX_W-1:0]   prop_q;
	logic [IDX_W-1:0]   acc_q;
	logic [IDX_W-1:0]   cur_q;
	logic [FIELD_W-1:0] rank_new_q;

	// Preference and rank tables, one read port each with registered data
	logic [FIELD_W-1:0] pref_mem [MEM_DEPTH];
	logic [FIELD_W-1:0] rank_mem [MEM_DEPTH];
	logic [FIELD_W-1:0] pref_rd_q;
	logic [FIELD_W-1:0] rank_rd_q;

	// Request fields
	req_type_t          req;
	logic [FIELD_W-1:0] person;
	logic [FIELD_W-1:0] position;
	logic [FIELD_W-1:0] preferred;
	logic               in_xfer;
	logic               out_xfer;
	logic               load_ok;
	logic               pref_we;
	logic               rank_we;
	logic [ADDR_W-1:0]  pref_wa;
	logic [ADDR_W-1:0]  rank_wa;
	logic [ADDR_W-1:0]  pref_ra;
	logic [ADDR_W-1:0]  rank_ra;
	logic [CNT_W-1:0]   eff_n;

	// Head of the queue and its list position
	logic [IDX_W-1:0]   head_prop;
	logic [CNT_W-1:0]   head_choice;
	logic               head_exhausted;
	logic               pref_out_of_range;
	logic               rank_better;
	logic               last_result;
	logic [IDX_W-1:0]   head_next;
	logic [SUM_W-1:0]   tail_sum;
	logic [IDX_W-1:0]   tail_idx;

	assign req       = req_type_t'(s_axis_tuser);
	assign person    = s_axis_tdata[3:0];
	assign position  = s_axis_tdata[7:4];
	assign preferred = s_axis_tdata[11:8];

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_xfer       = s_axis_tvalid && s_axis_tready;
	assign out_xfer      = m_axis_tvalid && m_axis_tready;

	// A load whose indices lie beyond the tables is ignored.
	assign load_ok = (32'(person) < MAX_PEOPLE) && (32'(position) < MAX_PEOPLE);
	assign pref_we = in_xfer && (req == REQ_LOAD_PROPOSER) && load_ok;
	assign rank_we = in_xfer && (req == REQ_LOAD_ACCEPTOR) && load_ok
		&& (32'(preferred) < MAX_PEOPLE);
	assign pref_wa = {IDX_W'(person), IDX_W'(position)};
	assign rank_wa = {IDX_W'(person), IDX_W'(preferred)};

	// A count of zero runs as one person; a count above the table size is capped.
	always_comb begin
		if (num_people_q == '0) begin
			eff_n = CNT_W'(1);
		end else if (32'(num_people_q) > MAX_PEOPLE) begin
			eff_n = CNT_W'(MAX_PEOPLE);
		end else begin
			eff_n = CNT_W'(num_people_q);
		end
	end

	assign head_prop      = free_fifo_q[fifo_head_q];
	assign head_choice    = next_choice_q[head_prop];
	assign head_exhausted = (head_choice >= n_q);

	assign pref_ra = {head_prop, head_choice[IDX_W-1:0]};
	// The first rank read fetches the proposer's rank, the second the
	// current partner's rank at the same acceptor.
	assign rank_ra = (state_q == ST_PROP) ? {acc_q, prop_q} : {acc_q, cur_q};

	assign pref_out_of_range = (32'(pref_rd_q) >= 32'(n_q));
	// Ties keep the current partner, so only a strictly smaller rank wins.
	assign rank_better       = (rank_new_q < rank_rd_q);
	assign last_result       = ((CNT_W'(acc_q) + CNT_W'(1)) == n_q);

	// Queue pointer arithmetic: the head wraps at the table size, and a
	// pushed proposer lands at head plus count, modulo the same size.
	assign head_next = (32'(fifo_head_q) == MAX_PEOPLE - 1) ? '0 : fifo_head_q + IDX_W'(1);
	assign tail_sum  = SUM_W'(fifo_head_q) + SUM_W'(fifo_count_q);
	assign tail_idx  = (32'(tail_sum) >= MAX_PEOPLE) ?
		IDX_W'(tail_sum - SUM_W'(MAX_PEOPLE)) : IDX_W'(tail_sum);

	// Tables: written by load transfers, read one entry per cycle by the sequencer
	always_ff @(posedge clk) begin
		if (pref_we) begin
			pref_mem[pref_wa] <= preferred;
		end
		pref_rd_q <= pref_mem[pref_ra];
	end

	always_ff @(posedge clk) begin
		if (rank_we) begin
			rank_mem[rank_wa] <= position;
		end
		rank_rd_q <= rank_mem[rank_ra];
	end

	// Sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			num_people_q   <= CFG_RESET;
			n_q            <= CNT_W'(MAX_PEOPLE);
			fifo_head_q    <= '0;
			fifo_count_q   <= '0;
			engaged_flag_q <= '0;
			acc_q          <= '0;
			for (int i = 0; i < MAX_PEOPLE; i++) begin
				next_choice_q[i] <= '0;
			end
		end else begin
			if (cfg_wr_en) begin
				num_people_q <= cfg_wr_data;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_xfer && (req == REQ_RUN)) begin
						n_q            <= eff_n;
						fifo_head_q    <= '0;
						fifo_count_q   <= eff_n;
						engaged_flag_q <= '0;
						for (int i = 0; i < MAX_PEOPLE; i++) begin
							next_choice_q[i] <= '0;
						end
						state_q <= ST_HEAD;
					end
				end
				ST_HEAD: begin
					if (fifo_count_q == '0) begin
						acc_q   <= '0;
						state_q <= ST_OUT;
					end else if (head_exhausted) begin
						// List used up: the proposer leaves the queue single.
						fifo_head_q  <= head_next;
						fifo_count_q <= fifo_count_q - CNT_W'(1);
					end else begin
						next_choice_q[head_prop] <= head_choice + CNT_W'(1);
						state_q                  <= ST_PREF;
					end
				end
				ST_PREF: begin
					// An acceptor outside the run only costs the proposer a list entry.
					if (pref_out_of_range) begin
						state_q <= ST_HEAD;
					end else begin
						acc_q   <= IDX_W'(pref_rd_q);
						state_q <= ST_PROP;
					end
				end
				ST_PROP: begin
					if (!engaged_flag_q[acc_q]) begin
						engaged_flag_q[acc_q] <= 1'b1;
						fifo_head_q           <= head_next;
						fifo_count_q          <= fifo_count_q - CNT_W'(1);
						state_q               <= ST_HEAD;
					end else begin
						state_q <= ST_RANK;
					end
				end
				ST_RANK: begin
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					// A trade-up pops the proposer and pushes the displaced
					// partner, so the count is unchanged.
					if (rank_better) begin
						fifo_head_q <= head_next;
					end
					state_q <= ST_HEAD;
				end
				ST_OUT: begin
					if (out_xfer) begin
						if (last_result) begin
							state_q <= ST_IDLE;
						end else begin
							acc_q <= acc_q + IDX_W'(1);
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Data registers of the run; every entry that is read is written first.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_xfer && (req == REQ_RUN)) begin
					for (int i = 0; i < MAX_PEOPLE; i++) begin
						free_fifo_q[i] <= IDX_W'(i);
					end
				end
			end
			ST_HEAD: begin
				prop_q <= head_prop;
			end
			ST_PROP: begin
				if (!engaged_flag_q[acc_q]) begin
					engaged_to_q[acc_q] <= prop_q;
				end else begin
					cur_q <= engaged_to_q[acc_q];
				end
			end
			ST_RANK: begin
				rank_new_q <= rank_rd_q;
			end
			ST_CMP: begin
				if (rank_better) begin
					free_fifo_q[tail_idx] <= cur_q;
					engaged_to_q[acc_q]   <= prop_q;
				end
			end
			default: begin
			end
		endcase
	end

	// One result per acceptor, in acceptor order; the partner reads as zero
	// for an acceptor left single.
	assign m_axis_tvalid = (state_q == ST_OUT);
	assign m_axis_tuser  = engaged_flag_q[acc_q];
	assign m_axis_tlast  = last_result;
	assign m_axis_tdata  = {
		engaged_flag_q[acc_q] ? FIELD_W'(engaged_to_q[acc_q]) : FIELD_W'(0),
		FIELD_W'(acc_q)
	};

endmodule

### dv/stable_matching_engine_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stable matching engine testbench
// Loads preference and rank tables, runs the matching and checks every
// pairing transfer against a predictor of deferred acceptance. The
// predictor is kept here in the bench. Covers directed corner cases, then
// random phases over several people counts, with random stalls on both
// streams.
// ----------------------------------------------------------------------------
module stable_matching_engine_test;
	import sme_pkg::*;

	localparam int PEOPLE_MAX   = 16;
	localparam int TABLE_DEPTH  = PEOPLE_MAX * PEOPLE_MAX;
	localparam int SIDE_MODEL   = 0;	// tables as the block holds them, per accepted transfer
	localparam int SIDE_PLAN    = 1;	// tables as the stimulus plan has queued them
	localparam int QUIET_CYCLES = 8;	// leaves ample margin for trailing loads to settle
	localparam int ITEM_TARGET  = 370;
	localparam int IDLE_PERCENT = 13;
	localparam int PRINT_LIMIT  = 100;

	// One request transfer as the stimulus plan holds it.
	typedef struct packed {
		req_type_t  kind;
		logic [3:0] person;
		logic [3:0] position;
		logic [3:0] preferred;
	} request_t;

	// One pairing transfer, field for field as the result stream carries it.
	typedef struct packed {
		logic [3:0] acceptor;
		logic [3:0] partner;
		logic       matched;
		logic       last;
	} pairing_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_wr_en = 1'b0;
	logic [CFG_W-1:0]      cfg_wr_data = '0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;	// [3:0] person, [7:4] position, [11:8] preferred
	logic [REQ_W-1:0]      s_axis_tuser = '0;	// [1:0] req_type
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;		// [3:0] acceptor, [7:4] partner
	logic                  m_axis_tuser;		// [0] matched
	logic                  m_axis_tlast;

	stable_matching_engine u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always #2 clk = ~clk;

	// Two copies of the preference and rank tables. The model copy follows the
	// transfers that the block has actually accepted; the plan copy follows what
	// the stimulus has queued so far, and lets the plan see which entries a run
	// would read before it queues that run. Entries stay unknown until written.
	logic [3:0] pref_tab [2][TABLE_DEPTH];
	logic [3:0] rank_tab [2][TABLE_DEPTH];
	pairing_t   solved [PEOPLE_MAX];

	request_t   pending [$];	// requests waiting to be driven
	pairing_t   expected [$];	// pairings predicted but not yet seen
	logic [CFG_W-1:0] model_people = CFG_RESET;
	int         plan_n = PEOPLE_MAX;
	bit         req_taken = 1'b0;
	bit         steady = 1'b0;	// set to suspend idling on both streams
	int         errors = 0;
	int         items_planned = 0;
	int         runs_seen = 0;
	int         settings_done = 0;
	int         pairings_checked = 0;

	// Effective number of people: a count of zero acts as one, and anything
	// above the table size acts as the table size.
	function automatic int people_in_play(input logic [CFG_W-1:0] value);
		if (value == '0) begin
			return 1;
		end
		if (int'(value) > PEOPLE_MAX) begin
			return PEOPLE_MAX;
		end
		return int'(value);
	endfunction

	// Proposer-optimal deferred acceptance over one copy of the tables. The free
	// proposers wait in a circular queue; the head proposes down its list, and an
	// engaged acceptor only trades up on a strictly better rank, sending the
	// displaced proposer to the tail. Proposals to acceptors outside the count are
	// skipped, and a proposer with nothing left on its list is dropped single.
	// Returns -1 with the pairings in solved, or the first unwritten entry that
	// the run would read: a preference index, or TABLE_DEPTH plus a rank index.
	function automatic int settle_matching(input int side, input int n);
		int next_pick [PEOPLE_MAX];
		bit taken [PEOPLE_MAX];
		int held_by [PEOPLE_MAX];
		int line [PEOPLE_MAX];
		int head, count, m, w, cur, i, slot;
		for (i = 0; i < PEOPLE_MAX; i++) begin
			next_pick[i] = 0;
			taken[i] = 1'b0;
			held_by[i] = 0;
			line[i] = 0;
		end
		head = 0;
		count = 0;
		for (i = 0; i < n; i++) begin
			line[(head + count) % PEOPLE_MAX] = i;
			count++;
		end
		while (count > 0) begin
			m = line[head];
			if (next_pick[m] >= n) begin
				head = (head + 1) % PEOPLE_MAX;
				count--;
				continue;
			end
			slot = m * PEOPLE_MAX + next_pick[m];
			if ($isunknown(pref_tab[side][slot])) begin
				return slot;
			end
			w = int'(pref_tab[side][slot]);
			next_pick[m]++;
			if (w >= n) begin
				continue;
			end
			if (!taken[w]) begin
				taken[w] = 1'b1;
				held_by[w] = m;
				head = (head + 1) % PEOPLE_MAX;
				count--;
			end else begin
				cur = held_by[w];
				if ($isunknown(rank_tab[side][w * PEOPLE_MAX + m])) begin
					return TABLE_DEPTH + w * PEOPLE_MAX + m;
				end
				if ($isunknown(rank_tab[side][w * PEOPLE_MAX + cur])) begin
					return TABLE_DEPTH + w * PEOPLE_MAX + cur;
				end
				// A tie keeps the current partner.
				if (rank_tab[side][w * PEOPLE_MAX + m] < rank_tab[side][w * PEOPLE_MAX + cur]) begin
					head = (head + 1) % PEOPLE_MAX;
					count--;
					line[(head + count) % PEOPLE_MAX] = cur;
					count++;
					held_by[w] = m;
				end
			end
		end
		for (w = 0; w < n; w++) begin
			solved[w].acceptor = 4'(w);
			solved[w].partner  = taken[w] ? 4'(held_by[w]) : 4'd0;
			solved[w].matched  = taken[w];
			solved[w].last     = (w == n - 1);
		end
		return -1;
	endfunction

	task automatic report(input string what);
		errors++;
		if (errors <= PRINT_LIMIT) begin
			$display("%0t ns: mismatch: %s", $time, what);
		end
	endtask

	// Queue one request and mirror its effect on the plan copy of the tables.
	// An acceptor load stores the position as that acceptor's rank of the
	// preferred proposer.
	task automatic queue_request(input req_type_t kind, input int person, input int position,
			input int preferred);
		request_t r;
		r.kind      = kind;
		r.person    = 4'(person);
		r.position  = 4'(position);
		r.preferred = 4'(preferred);
		pending.push_back(r);
		case (kind)
			REQ_LOAD_PROPOSER: begin
				pref_tab[SIDE_PLAN][person * PEOPLE_MAX + position] = 4'(preferred);
			end
			REQ_LOAD_ACCEPTOR: begin
				rank_tab[SIDE_PLAN][person * PEOPLE_MAX + preferred] = 4'(position);
			end
			default: begin
			end
		endcase
		if (kind != REQ_NONE) begin
			items_planned++;
		end
	endtask

	// Queue a run, first loading with random content every entry that the run
	// would otherwise read unwritten. Filled preferences mostly name acceptors
	// within the count so that runs reach contention and trading up.
	task automatic plan_run();
		int miss;
		int pick;
		miss = settle_matching(SIDE_PLAN, plan_n);
		while (miss >= 0) begin
			if (miss < TABLE_DEPTH) begin
				pick = ($urandom_range(3) != 0) ? $urandom_range(plan_n - 1) : $urandom_range(15);
				queue_request(REQ_LOAD_PROPOSER, miss / PEOPLE_MAX, miss % PEOPLE_MAX, pick);
			end else begin
				miss = miss - TABLE_DEPTH;
				queue_request(REQ_LOAD_ACCEPTOR, miss / PEOPLE_MAX, $urandom_range(15),
					miss % PEOPLE_MAX);
			end
			miss = settle_matching(SIDE_PLAN, plan_n);
		end
		queue_request(REQ_RUN, $urandom_range(15), $urandom_range(15), $urandom_range(15));
	endtask

	// Random table rewrites, either inside the region that the current count
	// reads or anywhere in the tables, with the odd unused request mixed in.
	task automatic scatter_loads(input int count, input bit in_region);
		int i, who, pos, pick;
		for (i = 0; i < count; i++) begin
			if (in_region) begin
				who  = $urandom_range(plan_n - 1);
				pos  = $urandom_range(plan_n - 1);
				pick = ($urandom_range(3) != 0) ? $urandom_range(plan_n - 1) : $urandom_range(15);
			end else begin
				who  = $urandom_range(15);
				pos  = $urandom_range(15);
				pick = $urandom_range(15);
			end
			if ($urandom_range(1) != 0) begin
				queue_request(REQ_LOAD_ACCEPTOR, who, pos, pick);
			end else begin
				queue_request(REQ_LOAD_PROPOSER, who, pos, pick);
			end
			if ($urandom_range(19) == 0) begin
				queue_request(REQ_NONE, $urandom_range(15), $urandom_range(15), $urandom_range(15));
			end
		end
	endtask

	// Wait until every queued request has been taken and every predicted pairing
	// has arrived, then give a trailing load time to settle inside the block.
	task automatic wait_quiet();
		while (pending.size() != 0 || s_axis_tvalid || expected.size() != 0) begin
			@(posedge clk);
		end
		repeat (QUIET_CYCLES) @(posedge clk);
	endtask

	// The count register is only written while the block is idle.
	task automatic set_people(input int value);
		wait_quiet();
		@(negedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= CFG_W'(value);
		@(negedge clk);
		cfg_wr_en   <= 1'b0;
		plan_n = people_in_play(CFG_W'(value));
		settings_done++;
	endtask

	// Request driver. A new transfer is offered only once the previous one has
	// been taken, so valid stays up across back-to-back transfers without being
	// lowered and raised again in the same step.
	always @(negedge clk) begin : drive_requests
		request_t nxt;
		bit       offer;
		if (!s_axis_tvalid || req_taken) begin
			offer = arst_n && pending.size() != 0
				&& (steady || $urandom_range(99) >= IDLE_PERCENT);
			if (offer) begin
				nxt = pending.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tdata  <= {4'b0000, nxt.preferred, nxt.position, nxt.person};
				s_axis_tuser  <= nxt.kind;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// Result sink: back-pressure at random, except in the steady stretch.
	always @(negedge clk) begin
		m_axis_tready <= arst_n && (steady || $urandom_range(99) >= IDLE_PERCENT);
	end

	// Monitor. Accepted requests update the model tables; a run predicts one
	// pairing per acceptor. Every pairing transfer is checked against the oldest
	// prediction, field by field.
	always @(posedge clk) begin : watch_streams
		req_type_t  kind;
		logic [3:0] person, position, preferred;
		pairing_t   got, want;
		int         n, miss, k;
		req_taken <= s_axis_tvalid && s_axis_tready;
		if (cfg_wr_en) begin
			model_people <= cfg_wr_data;
		end
		if (s_axis_tvalid && s_axis_tready) begin
			kind      = req_type_t'(s_axis_tuser);
			person    = s_axis_tdata[3:0];
			position  = s_axis_tdata[7:4];
			preferred = s_axis_tdata[11:8];
			case (kind)
				REQ_LOAD_PROPOSER: begin
					pref_tab[SIDE_MODEL][int'(person) * PEOPLE_MAX + int'(position)] = preferred;
				end
				REQ_LOAD_ACCEPTOR: begin
					rank_tab[SIDE_MODEL][int'(person) * PEOPLE_MAX + int'(preferred)] = position;
				end
				REQ_RUN: begin
					n = people_in_play(model_people);
					miss = settle_matching(SIDE_MODEL, n);
					if (miss >= 0) begin
						report($sformatf("run would read unloaded table entry %0d", miss));
					end else begin
						for (k = 0; k < n; k++) begin
							expected.push_back(solved[k]);
						end
					end
					runs_seen++;
				end
				default: begin
				end
			endcase
		end
		if (m_axis_tvalid && m_axis_tready) begin
			got.acceptor = m_axis_tdata[3:0];
			got.partner  = m_axis_tdata[7:4];
			got.matched  = m_axis_tuser;
			got.last     = m_axis_tlast;
			pairings_checked++;
			if (expected.size() == 0) begin
				report($sformatf("unexpected pairing for acceptor %0d", got.acceptor));
			end else begin
				want = expected.pop_front();
				if (got.acceptor !== want.acceptor || got.partner !== want.partner
						|| got.matched !== want.matched || got.last !== want.last) begin
					report($sformatf(
						"got acceptor %0d partner %0d matched %0b last %0b, want %0d %0d %0b %0b",
						got.acceptor, got.partner, got.matched, got.last,
						want.acceptor, want.partner, want.matched, want.last));
				end
			end
		end
	end

	// Stimulus plan.
	initial begin : stimulus
		int phase, value, order [PEOPLE_MAX], p, k, j, swap, runs, r;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Two people. Acceptor 0 prefers proposer 1, so proposer 0 is first
		// accepted and then displaced, and moves on to acceptor 1.
		set_people(2);
		queue_request(REQ_LOAD_PROPOSER, 0, 0, 0);
		queue_request(REQ_LOAD_PROPOSER, 0, 1, 1);
		queue_request(REQ_LOAD_PROPOSER, 1, 0, 0);
		queue_request(REQ_LOAD_PROPOSER, 1, 1, 1);
		queue_request(REQ_LOAD_ACCEPTOR, 0, 1, 0);
		queue_request(REQ_LOAD_ACCEPTOR, 0, 0, 1);
		queue_request(REQ_LOAD_ACCEPTOR, 1, 0, 0);
		queue_request(REQ_LOAD_ACCEPTOR, 1, 1, 1);
		plan_run();
		// Equal ranks: acceptor 0 keeps its first partner.
		queue_request(REQ_LOAD_ACCEPTOR, 0, 0, 0);
		plan_run();
		// Proposer 1 first names an acceptor beyond the count, then loses the
		// tie, runs out of list and stays single; acceptor 1 ends unmatched.
		queue_request(REQ_LOAD_PROPOSER, 1, 0, 3);
		queue_request(REQ_LOAD_PROPOSER, 1, 1, 0);
		plan_run();
		// The unused request code, and loads at the very ends of the tables.
		queue_request(REQ_NONE, 15, 15, 15);
		queue_request(REQ_LOAD_PROPOSER, 15, 15, 15);
		queue_request(REQ_LOAD_ACCEPTOR, 15, 15, 15);
		// A count of zero acts as one person. The sender holds off here until
		// every pairing so far has come back.
		set_people(0);
		plan_run();

		// Random phases: a fresh count each time, the extremes first. Small
		// counts dominate; large ones get scattered loads, not complete tables.
		phase = 0;
		while (items_planned < ITEM_TARGET) begin
			if (phase == 0) begin
				value = 31;
			end else if (phase == 1) begin
				value = 1;
			end else if (phase == 2) begin
				value = 16;
			end else begin
				r = $urandom_range(99);
				if (r < 65) begin
					value = $urandom_range(6, 2);
				end else if (r < 85) begin
					value = $urandom_range(15, 7);
				end else begin
					value = $urandom_range(31, 16);
				end
			end
			set_people(value);
			// The phase with a count of 16 and the one after it run without idling.
			steady = (phase == 2 || phase == 3);
			if (plan_n <= 6 && $urandom_range(1) != 0) begin
				// Complete permutation tables: every proposer ends matched.
				for (p = 0; p < plan_n; p++) begin
					for (k = 0; k < plan_n; k++) begin
						order[k] = k;
					end
					for (k = plan_n - 1; k > 0; k--) begin
						j = $urandom_range(k);
						swap = order[k];
						order[k] = order[j];
						order[j] = swap;
					end
					for (k = 0; k < plan_n; k++) begin
						queue_request(REQ_LOAD_PROPOSER, p, k, order[k]);
					end
					for (k = plan_n - 1; k > 0; k--) begin
						j = $urandom_range(k);
						swap = order[k];
						order[k] = order[j];
						order[j] = swap;
					end
					for (k = 0; k < plan_n; k++) begin
						queue_request(REQ_LOAD_ACCEPTOR, p, k, order[k]);
					end
				end
			end else begin
				scatter_loads($urandom_range(3 * plan_n, plan_n), 1'b1);
			end
			runs = $urandom_range(3, 1);
			for (r = 0; r < runs; r++) begin
				plan_run();
				scatter_loads($urandom_range(plan_n), $urandom_range(2) != 0);
			end
			phase++;
		end

		wait_quiet();
		$display("Covered %0d requests over %0d count settings and %0d matching runs.",
			items_planned, settings_done, runs_seen);
		$display("Checked %0d pairing transfers, %0d mismatches.", pairings_checked, errors);
		if (errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	// Watchdog. Its limit covers the slowest correct regression, a few dozen
	// runs of up to N*N proposal steps each, with sixteen stalled pairings
	// apiece, plus the loads with their gaps, and leaves a wide margin.
	initial begin
		#4000000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
